@@ design/sse_event_stream_parser_unit_assert.svh @@
// Assertion macros for the SSE event stream parser checker.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef SSE_EVENT_STREAM_PARSER_UNIT_ASSERT_SVH
`define SSE_EVENT_STREAM_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define SSEEP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset
`define SSEEP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/sseep_pkg.sv @@
// Shared types, constants and character tables for the SSE event stream parser.
// No dependencies; the other design files that use it refer to it by scoped names.
package sseep_pkg;

    localparam int TYPE_MAX    = 32;
    localparam int TYPE_LEN_W  = $clog2(TYPE_MAX + 1);
    localparam int TYPE_ADDR_W = $clog2(TYPE_MAX);

    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    localparam int MSG_LEN     = 7;
    localparam int EVENT_LEN   = 5;
    localparam int DATA_LEN    = 4;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_D     = 8'h64;

    localparam logic REQ_BYTE  = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_TYPE = 1'b1;

    typedef enum logic [1:0] {
        FK_OTHER = 2'd0,
        FK_EVENT = 2'd1,
        FK_DATA  = 2'd2
    } field_kind_t;

    typedef enum logic [1:0] {
        CMD_DATA    = 2'd0,
        CMD_DISP    = 2'd1,
        CMD_NL_DISP = 2'd2
    } cmd_kind_t;

    // One queued job for the back end
    typedef struct packed {
        cmd_kind_t               kind;
        logic [7:0]              data;
        logic [TYPE_LEN_W-1:0]   len;
        logic                    ovf;
    } cmd_t;

    function automatic logic [2:0] name_len(field_kind_t fk);
        case (fk)
            FK_EVENT: return 3'(EVENT_LEN);
            FK_DATA:  return 3'(DATA_LEN);
            default:  return 3'd0;
        endcase
    endfunction

    function automatic logic [7:0] word_char(field_kind_t fk, logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        if (fk == FK_EVENT)
        begin
            case (pos)
                3'd0:    ch = "e";
                3'd1:    ch = "v";
                3'd2:    ch = "e";
                3'd3:    ch = "n";
                3'd4:    ch = "t";
                default: ch = 8'h00;
            endcase
        end
        else
        begin
            case (pos)
                3'd0:    ch = "d";
                3'd1:    ch = "a";
                3'd2:    ch = "t";
                3'd3:    ch = "a";
                default: ch = 8'h00;
            endcase
        end
        return ch;
    endfunction

    function automatic logic [7:0] message_char(logic [2:0] idx);
        case (idx)
            3'd0:    return "m";
            3'd1:    return "e";
            3'd2:    return "s";
            3'd3:    return "s";
            3'd4:    return "a";
            3'd5:    return "g";
            3'd6:    return "e";
            default: return 8'h00;
        endcase
    endfunction

endpackage

@@ design/sse_event_stream_parser_unit.sv @@
// Server-Sent Events stream parser.
// Slave channel: one stream byte or one end-of-stream flush per transaction.
// Master channel: data payload bytes and event type bytes; tlast closes an event.
// A data value byte passes the command queue, the back end byte register and
// the output register before it is offered on the master side. The back end
// pops each queued output byte, then loads it into the output register; bytes
// of a stored event name go through a type store read then an output register
// load, the default name one byte per cycle while the receiver takes it. All
// stream bytes are taken one per cycle until the four-entry command queue ahead
// of the back end fills or a dispatch holds tready low, as below.
// After a transaction that dispatches an event the slave side holds tready low
// until the last name byte is loaded into the output register, since the next
// event line would write the same type store.
// Reset clears the line state, the pending flags and the output valid flag; the
// type store is not cleared and needs no clearing pass.
// When the receiver stalls the output register holds, the back end stops, the
// queue fills and tready drops.
// Depends on sseep_pkg, sseep_front, sseep_cmd_fifo, sseep_back and sseep_ram.
module sse_event_stream_parser_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] byte_value
    input  logic [1:0] s_tuser,   // [0] req_type, [1] dispatch_on_flush
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [0] item_kind, [1] name_truncated
    output logic       m_tlast
);

    logic                                fifo_full, fifo_empty;
    logic                                push, pop, disp_done;
    sseep_pkg::cmd_t                     push_cmd, head_cmd;
    logic                                store_we;
    logic [sseep_pkg::TYPE_ADDR_W-1:0]   store_waddr, store_raddr;
    logic [7:0]                          store_wdata, store_rdata;

    sseep_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .fifo_full   (fifo_full),
        .push        (push),
        .push_cmd    (push_cmd),
        .disp_done   (disp_done),
        .store_we    (store_we),
        .store_waddr (store_waddr),
        .store_wdata (store_wdata)
    );

    sseep_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .full     (fifo_full),
        .empty    (fifo_empty)
    );

    sseep_ram #(
        .WIDTH (8),
        .DEPTH (sseep_pkg::TYPE_MAX)
    ) u_type_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (store_wdata),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    sseep_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .fifo_empty  (fifo_empty),
        .head_cmd    (head_cmd),
        .pop         (pop),
        .disp_done   (disp_done),
        .store_raddr (store_raddr),
        .store_rdata (store_rdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

@@ design/sseep_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package dependency.
module sseep_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/sseep_cmd_fifo.sv @@
// Short command queue between the parser front end and the output back end.
// Depends on sseep_pkg for the command type and depth.
module sseep_cmd_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sseep_pkg::cmd_t   push_cmd,
    input  logic              pop,
    output sseep_pkg::cmd_t   head_cmd,
    output logic              full,
    output logic              empty
);

    sseep_pkg::cmd_t                     slot_reg [sseep_pkg::FIFO_DEPTH];
    logic [sseep_pkg::FIFO_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [sseep_pkg::FIFO_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [sseep_pkg::FIFO_CNT_W-1:0]    count_reg, count_next;
    logic                                do_push, do_pop;

    assign full     = (count_reg == sseep_pkg::FIFO_CNT_W'(sseep_pkg::FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ design/sseep_front.sv @@
// Parser front end: accepts stream bytes and flushes, tracks line and field
// state, writes event names into the type store and queues output commands.
// Depends on sseep_pkg.
module sseep_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,
    input  logic [1:0]                           s_tuser,
    input  logic                                 fifo_full,
    output logic                                 push,
    output sseep_pkg::cmd_t                      push_cmd,
    input  logic                                 disp_done,
    output logic                                 store_we,
    output logic [sseep_pkg::TYPE_ADDR_W-1:0]    store_waddr,
    output logic [7:0]                           store_wdata
);

    typedef enum logic [6:0] {
        PH_START       = 7'b0000001,
        PH_NAME        = 7'b0000010,
        PH_SKIP        = 7'b0000100,
        PH_DATA_FIRST  = 7'b0001000,
        PH_DATA_VAL    = 7'b0010000,
        PH_EVENT_FIRST = 7'b0100000,
        PH_EVENT_VAL   = 7'b1000000
    } phase_t;

    phase_t                              phase_reg, phase_next;
    logic [2:0]                          pos_reg, pos_next;
    sseep_pkg::field_kind_t              fk_reg, fk_next;
    logic                                pending_reg, pending_next;
    logic                                nonempty_reg, nonempty_next;
    logic [sseep_pkg::TYPE_LEN_W-1:0]    len_reg, len_next;
    logic                                ovf_reg, ovf_next;
    logic                                disp_out_reg, disp_out_next;

    logic        accept, req, force_disp;
    logic [7:0]  c;
    logic        do_end_line, do_take;
    logic        nl, data_emit, disp;
    logic [2:0]  nlen;

    assign s_tready    = !fifo_full && !disp_out_reg;
    assign accept      = s_tvalid && s_tready;
    assign c           = s_tdata;
    assign req         = s_tuser[0];
    assign force_disp  = s_tuser[1];
    assign nlen        = sseep_pkg::name_len(fk_reg);
    assign store_wdata = c;
    assign store_waddr = len_reg[sseep_pkg::TYPE_ADDR_W-1:0];

    assign do_end_line = accept && (((req == sseep_pkg::REQ_BYTE) && (c == sseep_pkg::CH_LF))
                                    || ((req == sseep_pkg::REQ_FLUSH) && (phase_reg != PH_START)));
    assign do_take     = accept && (req == sseep_pkg::REQ_BYTE)
                         && (c != sseep_pkg::CH_CR) && (c != sseep_pkg::CH_LF);

    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        fk_next       = fk_reg;
        pending_next  = pending_reg;
        nonempty_next = nonempty_reg;
        len_next      = len_reg;
        ovf_next      = ovf_reg;
        disp_out_next = disp_out_reg;
        nl            = 1'b0;
        data_emit     = 1'b0;
        disp          = 1'b0;
        store_we      = 1'b0;
        push_cmd      = '0;

        if (disp_done)
        begin
            disp_out_next = 1'b0;
        end

        if (do_end_line)
        begin
            if (phase_reg == PH_START)
            begin
                disp = pending_reg;
            end
            else if ((phase_reg == PH_NAME) && (fk_reg != sseep_pkg::FK_OTHER)
                     && (pos_reg == nlen))
            begin
                pending_next = 1'b1;
                if (fk_reg == sseep_pkg::FK_DATA)
                begin
                    nl = nonempty_reg;
                end
                else
                begin
                    len_next = '0;
                    ovf_next = 1'b0;
                end
            end
            phase_next = PH_START;
            pos_next   = '0;
            fk_next    = sseep_pkg::FK_OTHER;
        end

        if (do_take)
        begin
            case (phase_reg)
                PH_START:
                begin
                    if (c == sseep_pkg::CH_E)
                    begin
                        fk_next    = sseep_pkg::FK_EVENT;
                        pos_next   = 3'd1;
                        phase_next = PH_NAME;
                    end
                    else if (c == sseep_pkg::CH_D)
                    begin
                        fk_next    = sseep_pkg::FK_DATA;
                        pos_next   = 3'd1;
                        phase_next = PH_NAME;
                    end
                    else
                    begin
                        phase_next = PH_SKIP;
                    end
                end
                PH_NAME:
                begin
                    if (c == sseep_pkg::CH_COLON)
                    begin
                        if ((pos_reg == nlen) && (fk_reg == sseep_pkg::FK_DATA))
                        begin
                            nl           = nonempty_reg;
                            pending_next = 1'b1;
                            phase_next   = PH_DATA_FIRST;
                        end
                        else if ((pos_reg == nlen) && (fk_reg == sseep_pkg::FK_EVENT))
                        begin
                            len_next     = '0;
                            ovf_next     = 1'b0;
                            pending_next = 1'b1;
                            phase_next   = PH_EVENT_FIRST;
                        end
                        else
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                    else if ((pos_reg < nlen) && (c == sseep_pkg::word_char(fk_reg, pos_reg)))
                    begin
                        pos_next = pos_reg + 3'd1;
                    end
                    else
                    begin
                        phase_next = PH_SKIP;
                    end
                end
                PH_DATA_FIRST, PH_DATA_VAL:
                begin
                    phase_next = PH_DATA_VAL;
                    if ((phase_reg == PH_DATA_VAL) || (c != sseep_pkg::CH_SPACE))
                    begin
                        data_emit     = 1'b1;
                        nonempty_next = 1'b1;
                    end
                end
                PH_EVENT_FIRST, PH_EVENT_VAL:
                begin
                    phase_next = PH_EVENT_VAL;
                    if ((phase_reg == PH_EVENT_VAL) || (c != sseep_pkg::CH_SPACE))
                    begin
                        // Append to the name store, or drop and flag when full
                        if (len_reg < sseep_pkg::TYPE_LEN_W'(sseep_pkg::TYPE_MAX))
                        begin
                            store_we = 1'b1;
                            len_next = len_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        if (accept && (req == sseep_pkg::REQ_FLUSH) && force_disp && pending_next && !disp)
        begin
            disp = 1'b1;
        end

        push_cmd.data = nl ? sseep_pkg::CH_LF : c;
        if (disp)
        begin
            push_cmd.kind = nl ? sseep_pkg::CMD_NL_DISP : sseep_pkg::CMD_DISP;
            push_cmd.len  = len_next;
            push_cmd.ovf  = ovf_next;
            len_next      = '0;
            ovf_next      = 1'b0;
            pending_next  = 1'b0;
            nonempty_next = 1'b0;
            disp_out_next = 1'b1;
        end
        else
        begin
            push_cmd.kind = sseep_pkg::CMD_DATA;
        end
    end

    assign push = disp || nl || data_emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_START;
            pos_reg      <= '0;
            fk_reg       <= sseep_pkg::FK_OTHER;
            pending_reg  <= 1'b0;
            nonempty_reg <= 1'b0;
            len_reg      <= '0;
            ovf_reg      <= 1'b0;
            disp_out_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            fk_reg       <= fk_next;
            pending_reg  <= pending_next;
            nonempty_reg <= nonempty_next;
            len_reg      <= len_next;
            ovf_reg      <= ovf_next;
            disp_out_reg <= disp_out_next;
        end
    end

endmodule

@@ design/sseep_back.sv @@
// Output back end: pops queued commands and drives the result stream through
// an output register, reading the event name from the type store on dispatch.
// Depends on sseep_pkg.
module sseep_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 fifo_empty,
    input  sseep_pkg::cmd_t                      head_cmd,
    output logic                                 pop,
    output logic                                 disp_done,
    output logic [sseep_pkg::TYPE_ADDR_W-1:0]    store_raddr,
    input  logic [7:0]                           store_rdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [7:0]                           m_tdata,
    output logic [1:0]                           m_tuser,
    output logic                                 m_tlast
);

    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_BYTE = 5'b00010,
        B_MSG  = 5'b00100,
        B_RD   = 5'b01000,
        B_LD   = 5'b10000
    } back_state_t;

    back_state_t                         state_reg, state_next;
    logic [7:0]                          byte_reg, byte_next;
    logic                                disp_after_reg, disp_after_next;
    logic [sseep_pkg::TYPE_LEN_W-1:0]    len_reg, len_next;
    logic                                ovf_reg, ovf_next;
    logic [sseep_pkg::TYPE_LEN_W-1:0]    idx_reg, idx_next;
    logic                                out_valid_reg, out_valid_next;
    logic [7:0]                          out_byte_reg;
    logic                                out_kind_reg, out_last_reg, out_trunc_reg;

    logic        load_ok, load;
    logic        ld_kind, ld_last, ld_trunc;
    logic [7:0]  ld_byte;
    logic        type_last, msg_last;

    assign load_ok     = !out_valid_reg || m_tready;
    assign store_raddr = idx_reg[sseep_pkg::TYPE_ADDR_W-1:0];
    assign type_last   = ((idx_reg + 1'b1) == len_reg);
    assign msg_last    = (idx_reg == sseep_pkg::TYPE_LEN_W'(sseep_pkg::MSG_LEN - 1));

    always_comb
    begin
        state_next      = state_reg;
        byte_next       = byte_reg;
        disp_after_next = disp_after_reg;
        len_next        = len_reg;
        ovf_next        = ovf_reg;
        idx_next        = idx_reg;
        pop             = 1'b0;
        disp_done       = 1'b0;
        load            = 1'b0;
        ld_kind         = sseep_pkg::KIND_DATA;
        ld_byte         = byte_reg;
        ld_last         = 1'b0;
        ld_trunc        = 1'b0;

        case (state_reg)
            B_IDLE:
            begin
                if (!fifo_empty)
                begin
                    pop             = 1'b1;
                    byte_next       = head_cmd.data;
                    disp_after_next = (head_cmd.kind != sseep_pkg::CMD_DATA);
                    len_next        = head_cmd.len;
                    ovf_next        = head_cmd.ovf;
                    idx_next        = '0;
                    if (head_cmd.kind == sseep_pkg::CMD_DISP)
                    begin
                        state_next = (head_cmd.len == '0) ? B_MSG : B_RD;
                    end
                    else
                    begin
                        state_next = B_BYTE;
                    end
                end
            end
            B_BYTE:
            begin
                if (load_ok)
                begin
                    load = 1'b1;
                    if (disp_after_reg)
                    begin
                        state_next = (len_reg == '0) ? B_MSG : B_RD;
                    end
                    else
                    begin
                        state_next = B_IDLE;
                    end
                end
            end
            B_MSG:
            begin
                if (load_ok)
                begin
                    load     = 1'b1;
                    ld_kind  = sseep_pkg::KIND_TYPE;
                    ld_byte  = sseep_pkg::message_char(idx_reg[2:0]);
                    ld_last  = msg_last;
                    idx_next = idx_reg + 1'b1;
                    if (msg_last)
                    begin
                        state_next = B_IDLE;
                        disp_done  = 1'b1;
                    end
                end
            end
            B_RD:
            begin
                // Store address is presented this cycle, data lands next
                state_next = B_LD;
            end
            B_LD:
            begin
                if (load_ok)
                begin
                    load     = 1'b1;
                    ld_kind  = sseep_pkg::KIND_TYPE;
                    ld_byte  = store_rdata;
                    ld_last  = type_last;
                    ld_trunc = ovf_reg;
                    idx_next = idx_reg + 1'b1;
                    if (type_last)
                    begin
                        state_next = B_IDLE;
                        disp_done  = 1'b1;
                    end
                    else
                    begin
                        state_next = B_RD;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg       <= byte_next;
        disp_after_reg <= disp_after_next;
        len_reg        <= len_next;
        ovf_reg        <= ovf_next;
        idx_reg        <= idx_next;
        if (load)
        begin
            out_byte_reg  <= ld_byte;
            out_kind_reg  <= ld_kind;
            out_last_reg  <= ld_last;
            out_trunc_reg <= ld_trunc;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = {out_trunc_reg, out_kind_reg};
    assign m_tlast  = out_last_reg;

endmodule

@@ design/sseep_checker.sv @@
// Port-level checker for the SSE event stream parser, bound to the top level.
// Depends on sse_event_stream_parser_unit_assert.svh.
`include "sse_event_stream_parser_unit_assert.svh"

module sseep_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    // A stalled result holds its contents
    `SSEEP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

    // Data bytes carry neither the event close marker nor the truncation flag
    `SSEEP_ASSERT_IMPL(a_data_flags, m_tvalid && !m_tuser[0], !m_tlast && !m_tuser[1], "data byte with event flags")

    // An unfinished event name is not interrupted by a data byte
    `SSEEP_ASSERT_NEXT(a_name_cont, m_tvalid && m_tready && m_tuser[0] && !m_tlast, !m_tvalid || m_tuser[0], "event name interrupted")

    // The truncation flag stays steady across the bytes of one event name
    `SSEEP_ASSERT_NEXT(a_trunc_steady, m_tvalid && m_tready && m_tuser[0] && !m_tlast, !m_tvalid || (m_tuser[1] == $past(m_tuser[1])), "truncation flag changed within event")

endmodule

bind sse_event_stream_parser_unit sseep_checker u_checker (.*);

@@ sim/sse_event_stream_parser_unit_tb.sv @@
// Self-checking testbench for sse_event_stream_parser_unit: directed SSE lines, then random
// well-formed events mixed with noise, every output transaction checked against a predictor.
// Depends on sseep_pkg and the parser RTL only.
`timescale 1ns / 1ps

module sse_event_stream_parser_unit_tb;

    import sseep_pkg::*;

    localparam int CYCLE_LIMIT  = 4000000;
    localparam int RANDOM_ITEMS = 116;
    localparam int SETTLE_CYCLES = 64;

    localparam logic [39:0] EVENT_WORD   = "event";
    localparam logic [31:0] DATA_WORD    = "data";
    localparam logic [55:0] MESSAGE_WORD = "message";

    typedef enum logic [2:0] {
        LN_START,
        LN_NAME,
        LN_SKIP,
        LN_DATA_FIRST,
        LN_DATA_VAL,
        LN_EVENT_FIRST,
        LN_EVENT_VAL
    } line_state_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] value;
        logic       last;
        logic       cut;
    } parsed_byte_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic [1:0] s_tuser = 2'b00;   // [0] req_type, [1] dispatch_on_flush
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [7:0] out_byte
    logic [1:0] m_tuser;           // [0] item_kind, [1] name_truncated
    logic       m_tlast;

    // Parser state as the predictor sees it
    line_state_t           line_state;
    logic [2:0]            name_pos;
    field_kind_t           cur_field;
    logic                  event_open;
    logic                  payload_seen;
    logic [7:0]            type_name [TYPE_MAX];
    logic [TYPE_LEN_W-1:0] type_len;
    logic                  type_cut;

    parsed_byte_t parsed_q[$];
    parsed_byte_t head_byte;

    int  fail_count = 0;
    int  items_sent = 0;
    int  cycle_count = 0;
    bit  quiet_phase = 1'b0;
    int  hold_request = 0;
    int  hold_left = 0;
    int  stall_left = 0;
    bit  ready_next;

    sse_event_stream_parser_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[sse_event_stream_parser_unit] ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [2:0] field_name_len(input field_kind_t fk);
        if (fk == FK_EVENT)
            return 3'd5;
        if (fk == FK_DATA)
            return 3'd4;
        return 3'd0;
    endfunction

    function automatic logic [7:0] field_char(input field_kind_t fk, input logic [2:0] pos);
        if (fk == FK_EVENT)
            return EVENT_WORD[8 * (4 - pos) +: 8];
        return DATA_WORD[8 * (3 - (pos % 4)) +: 8];
    endfunction

    function automatic void reset_parser();
        line_state   = LN_START;
        name_pos     = 3'd0;
        cur_field    = FK_OTHER;
        event_open   = 1'b0;
        payload_seen = 1'b0;
        type_len     = '0;
        type_cut     = 1'b0;
    endfunction

    function automatic void push_byte(input logic kind, input logic [7:0] value,
                                      input logic last, input logic cut);
        parsed_byte_t b;
        b.kind  = kind;
        b.value = value;
        b.last  = last;
        b.cut   = cut;
        parsed_q.push_back(b);
    endfunction

    function automatic void emit_event_type();
        if (type_len == 0)
        begin
            for (int i = 0; i < 7; i++)
                push_byte(KIND_TYPE, MESSAGE_WORD[8 * (6 - i) +: 8], i == 6, 1'b0);
        end
        else
        begin
            for (int i = 0; i < type_len; i++)
                push_byte(KIND_TYPE, type_name[i], i == type_len - 1, type_cut);
        end
        type_len     = '0;
        type_cut     = 1'b0;
        event_open   = 1'b0;
        payload_seen = 1'b0;
    endfunction

    function automatic void open_data_line();
        // successive data lines of one event are joined by a newline
        if (payload_seen)
            push_byte(KIND_DATA, CH_LF, 1'b0, 1'b0);
        event_open = 1'b1;
    endfunction

    function automatic void open_event_line();
        type_len   = '0;
        type_cut   = 1'b0;
        event_open = 1'b1;
    endfunction

    function automatic void finish_line();
        if (line_state == LN_START)
        begin
            if (event_open)
                emit_event_type();
        end
        else if (line_state == LN_NAME && cur_field != FK_OTHER &&
                 name_pos == field_name_len(cur_field))
        begin
            if (cur_field == FK_DATA)
                open_data_line();
            else
                open_event_line();
        end
        line_state = LN_START;
        name_pos   = 3'd0;
        cur_field  = FK_OTHER;
    endfunction

    function automatic void store_type_char(input logic [7:0] c);
        if (type_len < TYPE_MAX)
        begin
            type_name[type_len] = c;
            type_len++;
        end
        else
            type_cut = 1'b1;
    endfunction

    function automatic void parse_char(input logic [7:0] c);
        logic [2:0] len;
        len = field_name_len(cur_field);
        case (line_state)
            LN_START:
            begin
                if (c == CH_E || c == CH_D)
                begin
                    cur_field  = (c == CH_E) ? FK_EVENT : FK_DATA;
                    name_pos   = 3'd1;
                    line_state = LN_NAME;
                end
                else
                    line_state = LN_SKIP;
            end
            LN_NAME:
            begin
                if (c == CH_COLON)
                begin
                    if (name_pos == len && cur_field == FK_DATA)
                    begin
                        open_data_line();
                        line_state = LN_DATA_FIRST;
                    end
                    else if (name_pos == len && cur_field == FK_EVENT)
                    begin
                        open_event_line();
                        line_state = LN_EVENT_FIRST;
                    end
                    else
                        line_state = LN_SKIP;
                end
                else if (name_pos < len && c == field_char(cur_field, name_pos))
                    name_pos++;
                else
                    line_state = LN_SKIP;
            end
            LN_DATA_FIRST, LN_DATA_VAL:
            begin
                // drop one leading space after the colon
                if (!(line_state == LN_DATA_FIRST && c == CH_SPACE))
                begin
                    push_byte(KIND_DATA, c, 1'b0, 1'b0);
                    payload_seen = 1'b1;
                end
                line_state = LN_DATA_VAL;
            end
            LN_EVENT_FIRST, LN_EVENT_VAL:
            begin
                if (!(line_state == LN_EVENT_FIRST && c == CH_SPACE))
                    store_type_char(c);
                line_state = LN_EVENT_VAL;
            end
            default: ;
        endcase
    endfunction

    function automatic void predict_item(input logic req, input logic [7:0] c,
                                         input logic force_flag);
        if (req == REQ_BYTE)
        begin
            if (c == CH_LF)
                finish_line();
            else if (c != CH_CR)
                parse_char(c);
        end
        else
        begin
            if (line_state != LN_START)
                finish_line();
            if (force_flag && event_open)
                emit_event_type();
        end
    endfunction

    // ---------------------------------------------------------------- checker

    task automatic compare_field(input string field, input logic [7:0] want_v,
                                 input logic [7:0] got_v);
        if (want_v !== got_v)
        begin
            $error("%s: expected %0h, got %0h", field, want_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (parsed_q.size() == 0)
            begin
                $error("output transaction with nothing outstanding: out_byte %0h", m_tdata);
                fail_count++;
            end
            else
            begin
                head_byte = parsed_q.pop_front();
                compare_field("item_kind", 8'(head_byte.kind), 8'(m_tuser[0]));
                compare_field("out_byte", head_byte.value, m_tdata);
                compare_field("last_of_event", 8'(head_byte.last), 8'(m_tlast));
                compare_field("name_truncated", 8'(head_byte.cut), 8'(m_tuser[1]));
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_phase || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    // hold-off requests take priority over random stalls
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            ready_next = 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            ready_next = 1'b0;
        end
        else if (!quiet_phase && $urandom_range(0, 3) == 0)
        begin
            stall_left = pick_gap();
            ready_next = 1'b0;
        end
        else
            ready_next = 1'b1;
        m_tready <= ready_next;
    end

    // ---------------------------------------------------------------- sender

    task automatic send_item(input logic req, input logic [7:0] value, input logic force_flag);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= {force_flag, req};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_item(req, value, force_flag);
        items_sent++;
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++)
            send_item(REQ_BYTE, text[i], $urandom_range(0, 1) == 1);
    endtask

    task automatic send_flush(input logic force_flag);
        send_item(REQ_FLUSH, 8'($urandom_range(0, 255)), force_flag);
    endtask

    task automatic send_value(input int len, input bit wild);
        logic [7:0] c;
        for (int i = 0; i < len; i++)
        begin
            c = wild ? 8'($urandom_range(0, 255)) : 8'($urandom_range(8'h21, 8'h7E));
            if (c == CH_LF)
                c = CH_COLON;
            send_item(REQ_BYTE, c, $urandom_range(0, 1) == 1);
        end
    endtask

    task automatic send_eol();
        if ($urandom_range(0, 3) == 0)
            send_item(REQ_BYTE, CH_CR, $urandom_range(0, 1) == 1);
        send_item(REQ_BYTE, CH_LF, $urandom_range(0, 1) == 1);
    endtask

    task automatic send_separator();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14)
            send_text(": ");
        else if (r < 19)
            send_text(":");
        else
            send_text(":  ");
    endtask

    task automatic send_random_line();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
        begin
            send_text("data");
            send_separator();
            send_value($urandom_range(0, 6), $urandom_range(0, 4) == 0);
        end
        else if (r < 6)
        begin
            send_text("event");
            send_separator();
            // now and then a name near or past the length the type store can hold
            if ($urandom_range(0, 7) == 0)
                send_value($urandom_range(TYPE_MAX - 2, TYPE_MAX + 8), 1'b0);
            else
                send_value($urandom_range(0, 6), $urandom_range(0, 4) == 0);
        end
        else if (r == 6)
        begin
            send_text(":");
            send_value($urandom_range(0, 5), 1'b1);
        end
        else if (r == 7)
        begin
            send_text($urandom_range(0, 1) ? "id: " : "retry:");
            send_value($urandom_range(1, 3), 1'b0);
        end
        else if (r == 8)
        begin
            case ($urandom_range(0, 5))
                0: send_text("dat:x");
                1: send_text("datax: y");
                2: send_text("evnt:z");
                3: send_text("data");
                4: send_text("event");
                default: send_text("e:");
            endcase
        end
        send_eol();
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_data_lines();
        send_text("data: hi\r\ndata:");
        send_item(REQ_BYTE, 8'hFF, 1'b1);
        send_item(REQ_BYTE, 8'h00, 1'b0);
        send_text("\n\n");
    endtask

    task automatic test_event_name();
        send_text("event: up\ndata:x\n\n");
    endtask

    task automatic test_name_overflow();
        send_text("event:");
        for (int i = 0; i < TYPE_MAX + 2; i++)
            send_item(REQ_BYTE, 8'h41 + 8'(i % 26), 1'b0);
        send_text("\n\n");
    endtask

    task automatic test_line_oddities();
        // comment, event and data lines without a colon, ignored fields
        send_text(":c\nevent\n\ndata\ndata:a\n\nid:1\nevenx:y\n\n");
    endtask

    task automatic test_flush();
        send_text("data:z");
        send_flush(1'b1);
        send_text("data:q\n");
        send_flush(1'b0);
        send_flush(1'b1);
        send_flush(1'b0);
    endtask

    task automatic test_backpressure();
        quiet_phase  = 1'b1;
        hold_request = 300;
        send_text("data:");
        send_value(24, 1'b0);
        send_text("\n\n");
        quiet_phase = 1'b0;
    endtask

    task automatic test_random_stream();
        int target;
        int n_lines;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            quiet_phase = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 9) == 0)
            begin
                // raw noise over the whole input range
                repeat ($urandom_range(1, 6))
                    send_item($urandom_range(0, 4) == 0, 8'($urandom_range(0, 255)),
                              $urandom_range(0, 1) == 1);
            end
            else
            begin
                n_lines = $urandom_range(1, 4);
                repeat (n_lines)
                    send_random_line();
                case ($urandom_range(0, 9))
                    0:       send_flush(1'b1);
                    1:       send_flush(1'b0);
                    2:       ;
                    default: send_eol();
                endcase
            end
        end
        quiet_phase = 1'b0;
    endtask

    initial
    begin
        reset_parser();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_data_lines();
        test_event_name();
        test_name_overflow();
        test_line_oddities();
        test_flush();
        test_backpressure();
        test_random_stream();
        s_tvalid <= 1'b0;
        while (parsed_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("[sse_event_stream_parser_unit] OK");
        else
            $display("[sse_event_stream_parser_unit] ERROR");
        $finish;
    end

endmodule
